@@ rtl/core/sorted_timeout_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Sorted timeout queue: assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMEOUT_QUEUE_DEFINES_SVH
`define SORTED_TIMEOUT_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define STQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STQ_ASSERT(lbl, clk, rst, prop, msg)
`define STQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted timeout queue: package
// Item and result types, operation and status codes, time constants.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
   localparam logic [29:0] RES_NS_RESET = 30'd10000000;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_RES_SECONDS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RES_NANOSECONDS = 1'b1;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_REL   = 2'd1,
      KIND_ABS   = 2'd2,
      KIND_UNREG = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_BUSY    = 2'd2
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  slot;
      logic [31:0] when_s;
      logic [29:0] when_ns;
      logic        slot_bad;
      logic        ns_bad;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic        fired;
      logic [3:0]  fired_slot;
      logic [31:0] left_s;
      logic [29:0] left_ns;
      logic [31:0] now_s;
      logic [29:0] now_ns;
      logic        last;
   } result_type;

endpackage

@@ rtl/core/stq_ram.sv @@
// ----------------------------------------------------------------------------
// Sorted timeout queue: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stq_ram #(
   parameter int WIDTH = 62,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/stq_fifo.sv @@
// ----------------------------------------------------------------------------
// Sorted timeout queue: small register FIFO
// Decouples two sides; push/full on one end, pop/empty on the other.
// ----------------------------------------------------------------------------
module stq_fifo #(
   parameter int WIDTH   = 8,
   parameter int ENTRIES = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   logic [WIDTH-1:0] data_ff [ENTRIES];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(ENTRIES));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(ENTRIES - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(ENTRIES - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/stq_front.sv @@
// ----------------------------------------------------------------------------
// Sorted timeout queue: front end
// Accepts items, flags bad slot and bad nanoseconds, queues them.
// ----------------------------------------------------------------------------
module stq_front
   import stq_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  kind,
   input  logic [3:0]  slot,
   input  logic [31:0] when_s,
   input  logic [29:0] when_ns,
   input  logic        item_pop,
   output logic        item_valid,
   output item_type    item
);

   item_type             classified;
   logic                 queue_empty;
   logic [$bits(item_type)-1:0] queue_out;

   always_comb begin
      classified.kind     = kind_type'(kind);
      classified.slot     = slot;
      classified.when_s   = when_s;
      classified.when_ns  = when_ns;
      classified.slot_bad = ({1'b0, slot} >= 5'(SLOTS));
      classified.ns_bad   = (when_ns >= NS_PER_SEC);
   end

   stq_fifo #(
      .WIDTH   ($bits(item_type)),
      .ENTRIES (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .push_data (classified),
      .pop       (item_pop),
      .empty     (queue_empty),
      .pop_data  (queue_out)
   );

   assign item_valid = !queue_empty;
   assign item       = item_type'(queue_out);

endmodule

@@ rtl/core/stq_exec.sv @@
// ----------------------------------------------------------------------------
// Sorted timeout queue: execution back end
// Keeps time, the sorted slot list and due times; runs ticks, registration
// and unregistration, and pushes results into the result queue.
// ----------------------------------------------------------------------------
`include "sorted_timeout_queue_defines.svh"

module stq_exec
   import stq_pkg::*;
#(
   parameter int NSLOT = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   input  logic                 item_valid,
   output logic                 item_pop,
   input  item_type             item,
   input  logic                 out_full,
   output logic                 out_push,
   output result_type           out_result
);

   localparam int AW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
   localparam int CW = $clog2(NSLOT + 1);
   localparam logic [30:0] NS31 = {1'b0, NS_PER_SEC};

   typedef enum logic [10:0] {
      S_IDLE      = 11'b00000000001,
      S_TICK_NORM = 11'b00000000010,
      S_POP_RD    = 11'b00000000100,
      S_POP_CMP   = 11'b00000001000,
      S_UNREG_RD  = 11'b00000010000,
      S_UNREG_CMP = 11'b00000100000,
      S_REG_NORM  = 11'b00001000000,
      S_REG_WR    = 11'b00010000000,
      S_INS_RD    = 11'b00100000000,
      S_INS_CMP   = 11'b01000000000,
      S_RESP      = 11'b10000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      res_s_ff, res_s_in;
   logic [29:0]      res_ns_ff, res_ns_in;
   logic [31:0]      clk_s_ff, clk_s_in;
   logic [29:0]      clk_ns_ff, clk_ns_in;
   logic [NSLOT-1:0] active_ff, active_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             hold_valid_ff, hold_valid_in;
   logic [3:0]       hold_slot_ff, hold_slot_in;
   logic [3:0]       order_ff [NSLOT];
   logic [3:0]       order_in [NSLOT];
   item_type         item_ff, item_in;
   logic [30:0]      acc_ff, acc_in;
   logic [1:0]       carry_ff, carry_in;
   logic [31:0]      new_s_ff, new_s_in;
   logic [29:0]      new_ns_ff, new_ns_in;
   logic [CW-1:0]    idx_ff, idx_in;
   status_type       resp_status_ff, resp_status_in;
   logic             resp_fired_ff, resp_fired_in;
   logic [3:0]       resp_slot_ff, resp_slot_in;
   logic [31:0]      resp_left_s_ff, resp_left_s_in;
   logic [29:0]      resp_left_ns_ff, resp_left_ns_in;

   logic             ram_we;
   logic [AW-1:0]    ram_raddr;
   logic [61:0]      ram_rdata;
   logic [31:0]      due_s;
   logic [29:0]      due_ns;
   logic [AW-1:0]    slot_idx;
   logic [AW-1:0]    head_idx;
   logic [NSLOT-1:0] hit;
   logic [NSLOT-1:0] after;
   logic [30:0]      ns_diff;
   logic [29:0]      left_ns;

   assign csr_ready = 1'b1;
   assign slot_idx  = item_ff.slot[AW-1:0];
   assign head_idx  = order_ff[0][AW-1:0];
   assign due_s     = ram_rdata[61:30];
   assign due_ns    = ram_rdata[29:0];
   assign ns_diff   = {1'b0, due_ns} - {1'b0, clk_ns_ff};
   assign left_ns   = ns_diff[30] ? ns_diff[29:0] + NS_PER_SEC : ns_diff[29:0];

   // list position of the slot being removed, and everything after it
   always_comb begin
      for (int i = 0; i < NSLOT; i++) begin
         hit[i] = (order_ff[i] == item_ff.slot) && (CW'(i) < count_ff);
      end
      after[0] = hit[0];
      for (int i = 1; i < NSLOT; i++) begin
         after[i] = after[i-1] | hit[i];
      end
   end

   always_comb begin
      unique case (state_ff)
         S_UNREG_RD: ram_raddr = slot_idx;
         S_INS_RD:   ram_raddr = order_ff[idx_ff[AW-1:0]][AW-1:0];
         default:    ram_raddr = head_idx;
      endcase
   end

   stq_ram #(
      .WIDTH (62),
      .DEPTH (NSLOT)
   ) u_due_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_idx),
      .wdata ({new_s_ff, new_ns_ff}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in        = state_ff;
      res_s_in        = res_s_ff;
      res_ns_in       = res_ns_ff;
      clk_s_in        = clk_s_ff;
      clk_ns_in       = clk_ns_ff;
      active_in       = active_ff;
      count_in        = count_ff;
      hold_valid_in   = hold_valid_ff;
      hold_slot_in    = hold_slot_ff;
      order_in        = order_ff;
      item_in         = item_ff;
      acc_in          = acc_ff;
      carry_in        = carry_ff;
      new_s_in        = new_s_ff;
      new_ns_in       = new_ns_ff;
      idx_in          = idx_ff;
      resp_status_in  = resp_status_ff;
      resp_fired_in   = resp_fired_ff;
      resp_slot_in    = resp_slot_ff;
      resp_left_s_in  = resp_left_s_ff;
      resp_left_ns_in = resp_left_ns_ff;
      item_pop        = 1'b0;
      out_push        = 1'b0;
      ram_we          = 1'b0;

      out_result.status     = resp_status_ff;
      out_result.fired      = resp_fired_ff;
      out_result.fired_slot = resp_slot_ff;
      out_result.left_s     = resp_left_s_ff;
      out_result.left_ns    = resp_left_ns_ff;
      out_result.now_s      = clk_s_ff;
      out_result.now_ns     = clk_ns_ff;
      out_result.last       = 1'b1;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_RES_SECONDS:     res_s_in  = csr_data;
            CSR_RES_NANOSECONDS: res_ns_in = csr_data[29:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            resp_status_in  = STATUS_OK;
            resp_fired_in   = 1'b0;
            resp_slot_in    = '0;
            resp_left_s_in  = '0;
            resp_left_ns_in = '0;
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item;
               unique case (item.kind)
                  KIND_TICK: begin
                     acc_in   = {1'b0, clk_ns_ff} + {1'b0, res_ns_ff};
                     carry_in = '0;
                     state_in = S_TICK_NORM;
                  end
                  KIND_UNREG: begin
                     if (item.slot_bad || !active_ff[item.slot[AW-1:0]]) begin
                        resp_status_in = STATUS_INVALID;
                        state_in       = S_RESP;
                     end else begin
                        state_in = S_UNREG_RD;
                     end
                  end
                  default: begin
                     if (item.slot_bad || item.ns_bad) begin
                        resp_status_in = STATUS_INVALID;
                        state_in       = S_RESP;
                     end else if (active_ff[item.slot[AW-1:0]]) begin
                        resp_status_in = STATUS_BUSY;
                        state_in       = S_RESP;
                     end else begin
                        acc_in   = {1'b0, clk_ns_ff} + {1'b0, item.when_ns};
                        state_in = S_REG_NORM;
                     end
                  end
               endcase
            end
         end

         S_TICK_NORM: begin
            if (acc_ff >= NS31) begin
               acc_in   = acc_ff - NS31;
               carry_in = carry_ff + 1'b1;
            end else begin
               clk_s_in      = clk_s_ff + res_s_ff + {30'b0, carry_ff};
               clk_ns_in     = acc_ff[29:0];
               hold_valid_in = 1'b0;
               state_in      = S_POP_RD;
            end
         end

         S_POP_RD: begin
            if (count_ff == '0) begin
               resp_fired_in = hold_valid_ff;
               resp_slot_in  = hold_valid_ff ? hold_slot_ff : 4'd0;
               state_in      = S_RESP;
            end else begin
               state_in = S_POP_CMP;
            end
         end

         S_POP_CMP: begin
            if ({clk_s_ff, clk_ns_ff} < {due_s, due_ns}) begin
               resp_fired_in = hold_valid_ff;
               resp_slot_in  = hold_valid_ff ? hold_slot_ff : 4'd0;
               state_in      = S_RESP;
            end else if (!(hold_valid_ff && out_full)) begin
               if (hold_valid_ff) begin
                  out_push              = 1'b1;
                  out_result.status     = STATUS_OK;
                  out_result.fired      = 1'b1;
                  out_result.fired_slot = hold_slot_ff;
                  out_result.left_s     = '0;
                  out_result.left_ns    = '0;
                  out_result.last       = 1'b0;
               end
               hold_valid_in       = 1'b1;
               hold_slot_in        = order_ff[0];
               active_in[head_idx] = 1'b0;
               count_in            = count_ff - 1'b1;
               for (int i = 0; i < NSLOT - 1; i++) begin
                  order_in[i] = order_ff[i+1];
               end
               state_in = S_POP_RD;
            end
         end

         S_UNREG_RD: begin
            state_in = S_UNREG_CMP;
         end

         S_UNREG_CMP: begin
            if ({due_s, due_ns} > {clk_s_ff, clk_ns_ff}) begin
               resp_left_s_in  = due_s - clk_s_ff - {31'b0, ns_diff[30]};
               resp_left_ns_in = left_ns;
            end
            for (int i = 0; i < NSLOT - 1; i++) begin
               if (after[i]) begin
                  order_in[i] = order_ff[i+1];
               end
            end
            active_in[slot_idx] = 1'b0;
            count_in            = count_ff - 1'b1;
            state_in            = S_RESP;
         end

         S_REG_NORM: begin
            if (item_ff.kind == KIND_ABS) begin
               if ({item_ff.when_s, item_ff.when_ns} < {clk_s_ff, clk_ns_ff}) begin
                  resp_status_in = STATUS_INVALID;
                  state_in       = S_RESP;
               end else begin
                  new_s_in  = item_ff.when_s;
                  new_ns_in = item_ff.when_ns;
                  state_in  = S_REG_WR;
               end
            end else begin
               if (acc_ff >= NS31) begin
                  new_ns_in = 30'(acc_ff - NS31);
                  new_s_in  = clk_s_ff + item_ff.when_s + 32'd1;
               end else begin
                  new_ns_in = acc_ff[29:0];
                  new_s_in  = clk_s_ff + item_ff.when_s;
               end
               state_in = S_REG_WR;
            end
         end

         S_REG_WR: begin
            ram_we   = 1'b1;
            idx_in   = '0;
            state_in = S_INS_RD;
         end

         S_INS_RD: begin
            if (idx_ff == count_ff) begin
               order_in[idx_ff[AW-1:0]] = item_ff.slot;
               active_in[slot_idx]      = 1'b1;
               count_in                 = count_ff + 1'b1;
               state_in                 = S_RESP;
            end else begin
               state_in = S_INS_CMP;
            end
         end

         S_INS_CMP: begin
            if ({new_s_ff, new_ns_ff} < {due_s, due_ns}) begin
               for (int i = 1; i < NSLOT; i++) begin
                  if (CW'(i) > idx_ff) begin
                     order_in[i] = order_ff[i-1];
                  end
               end
               order_in[idx_ff[AW-1:0]] = item_ff.slot;
               active_in[slot_idx]      = 1'b1;
               count_in                 = count_ff + 1'b1;
               state_in                 = S_RESP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_INS_RD;
            end
         end

         S_RESP: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         res_s_ff      <= '0;
         res_ns_ff     <= RES_NS_RESET;
         clk_s_ff      <= '0;
         clk_ns_ff     <= '0;
         active_ff     <= '0;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         res_s_ff      <= res_s_in;
         res_ns_ff     <= res_ns_in;
         clk_s_ff      <= clk_s_in;
         clk_ns_ff     <= clk_ns_in;
         active_ff     <= active_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_slot_ff    <= hold_slot_in;
      order_ff        <= order_in;
      item_ff         <= item_in;
      acc_ff          <= acc_in;
      carry_ff        <= carry_in;
      new_s_ff        <= new_s_in;
      new_ns_ff       <= new_ns_in;
      idx_ff          <= idx_in;
      resp_status_ff  <= resp_status_in;
      resp_fired_ff   <= resp_fired_in;
      resp_slot_ff    <= resp_slot_in;
      resp_left_s_ff  <= resp_left_s_in;
      resp_left_ns_ff <= resp_left_ns_in;
   end

   `STQ_ASSERT(a_count_matches_active, clock, reset, $countones(active_ff) == int'(count_ff), "pending count differs from active slots")
   `STQ_ASSERT(a_count_in_range, clock, reset, count_ff <= CW'(NSLOT), "pending count over capacity")
   `STQ_ASSERT(a_push_not_full, clock, reset, out_push |-> !out_full, "result pushed into full queue")
   `STQ_ASSERT(a_clock_ns_range, clock, reset, clk_ns_ff < NS_PER_SEC, "current nanoseconds out of range")
   `STQ_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (count_ff == '0), "reset left pending entries")

endmodule

@@ rtl/core/sorted_timeout_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted timeout queue: top level
// Timer with a due-time ordered list of slot timeouts.
// ----------------------------------------------------------------------------
// Input items enter through req_push/req_full into a two-entry queue; each
// item is a tick, a relative or absolute registration, or an unregistration.
// Results leave through a two-entry queue read with rsp_empty/rsp_pop; a tick
// gives one result per expired slot (at least one), the others exactly one.
// The last result of an item has rsp_last set.
// One item runs at a time around a due-time RAM with one write and one read
// port. A tick adds the resolution, folds nanosecond carries, then pops
// each expired slot; registration writes the due time, then walks the list
// past each entry ahead of it; refused items answer without touching the list.
// The csr port takes a write in every cycle (csr_ready is always high) and
// should be written only while no item is in flight.
// Reset clears the time, the list and the queues; resolution returns to 0 s
// and 10 ms. A receiver that holds rsp_pop low stalls execution once the
// result queue fills, and the input queue then fills behind it.
// ----------------------------------------------------------------------------
module sorted_timeout_queue
   import stq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_kind,
   input  logic [3:0]           req_slot,
   input  logic [31:0]          req_when_seconds,
   input  logic [29:0]          req_when_nanoseconds,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [1:0]           rsp_status,
   output logic                 rsp_fired,
   output logic [3:0]           rsp_fired_slot,
   output logic [31:0]          rsp_left_seconds,
   output logic [29:0]          rsp_left_nanoseconds,
   output logic [31:0]          rsp_now_seconds,
   output logic [29:0]          rsp_now_nanoseconds,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam int NSLOT = (DEPTH < 16) ? DEPTH : 16;

   logic       item_valid;
   logic       item_pop;
   item_type   item;
   logic       out_full;
   logic       out_push;
   result_type out_result;
   result_type rsp;
   logic [$bits(result_type)-1:0] rsp_raw;

   stq_front #(
      .SLOTS (NSLOT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .kind       (req_kind),
      .slot       (req_slot),
      .when_s     (req_when_seconds),
      .when_ns    (req_when_nanoseconds),
      .item_pop   (item_pop),
      .item_valid (item_valid),
      .item       (item)
   );

   stq_exec #(
      .NSLOT (NSLOT)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_result (out_result)
   );

   stq_fifo #(
      .WIDTH   ($bits(result_type)),
      .ENTRIES (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .full      (out_full),
      .push_data (out_result),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_raw)
   );

   assign rsp                  = result_type'(rsp_raw);
   assign rsp_status           = rsp.status;
   assign rsp_fired            = rsp.fired;
   assign rsp_fired_slot       = rsp.fired_slot;
   assign rsp_left_seconds     = rsp.left_s;
   assign rsp_left_nanoseconds = rsp.left_ns;
   assign rsp_now_seconds      = rsp.now_s;
   assign rsp_now_nanoseconds  = rsp.now_ns;
   assign rsp_last             = rsp.last;

endmodule

@@ test/sorted_timeout_queue_test.sv @@
// ----------------------------------------------------------------------------
// Sorted timeout queue: testbench
// Drives ticks, registrations and unregistrations through the push/full
// port with random gaps, pops results with random stalls, and compares
// every result with a cycle-free timer model kept inside the bench. The
// tick resolution is reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_timeout_queue_test
   import stq_pkg::*;
();

   localparam int NSLOT = 16;
   localparam int WATCHDOG = 20000;
   localparam int DRAIN = 80;
   localparam logic [29:0] NS_MAX = 30'h3FFFFFFF;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  slot;
      logic [31:0] when_s;
      logic [29:0] when_ns;
   } op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [1:0] req_kind = '0;
   logic [3:0] req_slot = '0;
   logic [31:0] req_when_seconds = '0;
   logic [29:0] req_when_nanoseconds = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [1:0] rsp_status;
   logic rsp_fired;
   logic [3:0] rsp_fired_slot;
   logic [31:0] rsp_left_seconds, rsp_now_seconds;
   logic [29:0] rsp_left_nanoseconds, rsp_now_nanoseconds;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_full_q;
   logic rsp_empty_q;

   sorted_timeout_queue dut (.*);

   always #5 clock = ~clock;

   // timer model
   logic [31:0] res_s, now_s;
   logic [29:0] res_ns, now_ns;
   logic        armed [NSLOT];
   logic [31:0] due_s [NSLOT];
   logic [29:0] due_ns [NSLOT];
   logic [3:0]  due_order [$];

   result_type timer_results [$];
   op_type     pending_ops [$];
   int errors = 0;
   int accepted_ops = 0;
   int popped = 0;
   int fired_count = 0;
   int idle_cycles = 0;

   function automatic logic later_than(logic [31:0] as, logic [29:0] an,
                                       logic [31:0] bs, logic [29:0] bn);
      return (as > bs) || (as == bs && an > bn);
   endfunction

   function automatic result_type timer_result(status_type st, logic f, logic [3:0] fs,
                                              logic [31:0] ls, logic [29:0] ln);
      result_type r;
      r.status = st; r.fired = f; r.fired_slot = fs;
      r.left_s = ls; r.left_ns = ln;
      r.now_s = now_s; r.now_ns = now_ns; r.last = 1'b1;
      return r;
   endfunction

   function automatic void timer_step(op_type op);
      logic [63:0] sum;
      logic [31:0] ls;
      logic [29:0] ln;
      int pos, n;
      result_type r;
      if (op.kind == KIND_TICK) begin
         sum = 64'(now_ns) + 64'(res_ns);
         now_s = now_s + res_s + 32'(sum / 64'd1000000000);
         now_ns = 30'(sum % 64'd1000000000);
         n = 0;
         while (due_order.size() > 0 &&
                !later_than(due_s[due_order[0]], due_ns[due_order[0]], now_s, now_ns)) begin
            armed[due_order[0]] = 1'b0;
            r = timer_result(STATUS_OK, 1'b1, due_order[0], '0, '0);
            r.last = 1'b0;
            timer_results.push_back(r);
            void'(due_order.pop_front());
            n++;
         end
         if (n == 0) timer_results.push_back(timer_result(STATUS_OK, 1'b0, '0, '0, '0));
         else timer_results[$].last = 1'b1;
      end else if (op.kind == KIND_UNREG) begin
         if (!armed[op.slot]) begin
            timer_results.push_back(timer_result(STATUS_INVALID, 1'b0, '0, '0, '0));
         end else begin
            ls = '0; ln = '0;
            if (later_than(due_s[op.slot], due_ns[op.slot], now_s, now_ns)) begin
               ls = due_s[op.slot] - now_s;
               if (due_ns[op.slot] >= now_ns) begin
                  ln = due_ns[op.slot] - now_ns;
               end else begin
                  ln = due_ns[op.slot] + NS_PER_SEC - now_ns;
                  ls = ls - 32'd1;
               end
            end
            for (int i = 0; i < due_order.size(); i++)
               if (due_order[i] == op.slot) begin
                  due_order.delete(i);
                  break;
               end
            armed[op.slot] = 1'b0;
            timer_results.push_back(timer_result(STATUS_OK, 1'b0, '0, ls, ln));
         end
      end else if (op.when_ns >= NS_PER_SEC) begin
         timer_results.push_back(timer_result(STATUS_INVALID, 1'b0, '0, '0, '0));
      end else if (armed[op.slot]) begin
         timer_results.push_back(timer_result(STATUS_BUSY, 1'b0, '0, '0, '0));
      end else if (op.kind == KIND_ABS && later_than(now_s, now_ns, op.when_s, op.when_ns)) begin
         timer_results.push_back(timer_result(STATUS_INVALID, 1'b0, '0, '0, '0));
      end else begin
         if (op.kind == KIND_REL) begin
            sum = 64'(now_ns) + 64'(op.when_ns);
            due_s[op.slot] = now_s + op.when_s + 32'(sum / 64'd1000000000);
            due_ns[op.slot] = 30'(sum % 64'd1000000000);
         end else begin
            due_s[op.slot] = op.when_s;
            due_ns[op.slot] = op.when_ns;
         end
         armed[op.slot] = 1'b1;
         pos = due_order.size();
         for (int i = 0; i < due_order.size(); i++)
            if (later_than(due_s[due_order[i]], due_ns[due_order[i]],
                           due_s[op.slot], due_ns[op.slot])) begin
               pos = i;
               break;
            end
         due_order.insert(pos, op.slot);
         timer_results.push_back(timer_result(STATUS_OK, 1'b0, '0, '0, '0));
      end
   endfunction

   // driver
   int send_wait = 0;
   logic sender_hold = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_push && !req_full_q) begin
            accepted_ops++;
         end
         if (req_push && req_full_q) begin
            // keep item until accepted
         end else if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            req_push <= 1'b0;
         end else if (!sender_hold && pending_ops.size() > 0) begin
            req_kind <= pending_ops[0].kind;
            req_slot <= pending_ops[0].slot;
            req_when_seconds <= pending_ops[0].when_s;
            req_when_nanoseconds <= pending_ops[0].when_ns;
            timer_step(pending_ops.pop_front());
            req_push <= 1'b1;
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(posedge clock) req_full_q <= req_full;

   // monitor
   int pop_wait = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            popped++;
            if (timer_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual status %0d", $time,
                        rsp_status);
            end else begin
               result_type e, a;
               e = timer_results.pop_front();
               a = '{status_type'(rsp_status), rsp_fired, rsp_fired_slot, rsp_left_seconds,
                     rsp_left_nanoseconds, rsp_now_seconds, rsp_now_nanoseconds, rsp_last};
               if (e.fired) fired_count++;
               if (a !== e) begin
                  errors++;
                  $display("%0t: mismatch expected st=%0d f=%0d fs=%0d l=%0d.%0d n=%0d.%0d last=%0d",
                           $time, e.status, e.fired, e.fired_slot, e.left_s, e.left_ns,
                           e.now_s, e.now_ns, e.last);
                  $display("%0t:          actual   st=%0d f=%0d fs=%0d l=%0d.%0d n=%0d.%0d last=%0d",
                           $time, a.status, a.fired, a.fired_slot, a.left_s, a.left_ns,
                           a.now_s, a.now_ns, a.last);
               end
            end
         end
         idle_cycles <= ((req_push && !req_full) || (rsp_pop && !rsp_empty)) ? 0
                        : idle_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty_q) begin
            rsp_pop <= 1'b0;
            pop_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         end else if (pop_wait > 0) begin
            pop_wait <= pop_wait - 1;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) rsp_empty_q <= rsp_empty;

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic op_type make_op(kind_type k, logic [3:0] s, logic [31:0] ws,
                                      logic [29:0] wn);
      op_type o;
      o.kind = k; o.slot = s; o.when_s = ws; o.when_ns = wn;
      return o;
   endfunction

   function automatic logic [29:0] rand_ns();
      case ($urandom_range(0, 9))
         0: return NS_MAX;
         1: return 30'($urandom_range(1000000000, 1073741823));
         2: return NS_PER_SEC - 30'd1;
         3: return '0;
         default: return 30'($urandom_range(0, 999999999));
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_ops.size() > 0 || timer_results.size() > 0 || req_push)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_RES_SECONDS) res_s = value;
      else res_ns = value[29:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)
            pending_ops.push_back(make_op(KIND_TICK, 4'($urandom), $urandom, rand_ns()));
         else if (pick < 60)
            pending_ops.push_back(make_op(KIND_REL, 4'($urandom),
                                          ($urandom_range(0, 7) == 0) ? $urandom
                                          : $urandom_range(0, 2 * (res_s + 1)),
                                          rand_ns()));
         else if (pick < 80)
            pending_ops.push_back(make_op(KIND_ABS, 4'($urandom),
                                          ($urandom_range(0, 7) == 0) ? $urandom
                                          : now_s + $urandom_range(0, 3) - 1,
                                          rand_ns()));
         else
            pending_ops.push_back(make_op(KIND_UNREG, 4'($urandom), $urandom, rand_ns()));
      end
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         armed[i] = 1'b0; due_s[i] = '0; due_ns[i] = '0;
      end
      res_s = '0; res_ns = RES_NS_RESET; now_s = '0; now_ns = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset resolution, all operations and error cases
      pending_ops.push_back(make_op(KIND_TICK, 4'd0, '0, '0));
      pending_ops.push_back(make_op(KIND_REL, 4'd0, 32'd0, 30'd20000000));
      pending_ops.push_back(make_op(KIND_REL, 4'd1, 32'd0, 30'd20000000));
      pending_ops.push_back(make_op(KIND_REL, 4'd0, 32'd0, 30'd1));
      pending_ops.push_back(make_op(KIND_REL, 4'd2, 32'd0, NS_PER_SEC));
      pending_ops.push_back(make_op(KIND_ABS, 4'd3, 32'd0, 30'd0));
      pending_ops.push_back(make_op(KIND_ABS, 4'd4, 32'd0, 30'd10000000));
      pending_ops.push_back(make_op(KIND_ABS, 4'd5, 32'hFFFFFFFF, NS_PER_SEC - 30'd1));
      pending_ops.push_back(make_op(KIND_ABS, 4'd6, 32'd5, NS_MAX));
      pending_ops.push_back(make_op(KIND_UNREG, 4'd9, 32'hFFFFFFFF, NS_MAX));
      pending_ops.push_back(make_op(KIND_UNREG, 4'd5, '0, '0));
      pending_ops.push_back(make_op(KIND_TICK, 4'hF, 32'hFFFFFFFF, NS_MAX));
      pending_ops.push_back(make_op(KIND_TICK, 4'd0, '0, '0));
      pending_ops.push_back(make_op(KIND_REL, 4'hF, 32'd1, NS_PER_SEC - 30'd1));
      pending_ops.push_back(make_op(KIND_UNREG, 4'hF, '0, '0));
      pending_ops.push_back(make_op(KIND_TICK, 4'd0, '0, '0));
      wait_drained();

      // many slots expiring on one tick
      csr_write(CSR_RES_SECONDS, 32'd1);
      csr_write(CSR_RES_NANOSECONDS, 32'd0);
      for (int s = 0; s < NSLOT; s++)
         pending_ops.push_back(make_op(KIND_REL, 4'(s), 32'd0, 30'(s % 3)));
      pending_ops.push_back(make_op(KIND_TICK, 4'd0, '0, '0));
      wait_drained();
      random_phase(90);
      wait_drained();

      csr_write(CSR_RES_SECONDS, 32'hFFFFFFFF);
      csr_write(CSR_RES_NANOSECONDS, 32'(NS_PER_SEC - 30'd1));
      random_phase(60);
      wait_drained();

      csr_write(CSR_RES_SECONDS, 32'd0);
      csr_write(CSR_RES_NANOSECONDS, 32'h3FFFFFFF);
      random_phase(60);
      wait_drained();

      csr_write(CSR_RES_SECONDS, 32'd0);
      csr_write(CSR_RES_NANOSECONDS, 32'd0);
      random_phase(40);
      wait_drained();

      csr_write(CSR_RES_SECONDS, 32'd2);
      csr_write(CSR_RES_NANOSECONDS, 32'd300000000);
      random_phase(110);
      wait_drained();

      $display("%0d items sent, %0d results checked, %0d expirations seen",
               accepted_ops, popped, fired_count);
      $display("five resolution settings used, extremes included");
      if (errors == 0 && timer_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
